FILE: hw/rtl/pmlc_pkg.sv
// ----------------------------------------------------------------------------
// pmlc_pkg
// Shared types, fixed-width constants and the elaboration-time log2 helper
// for the PCM mixer with soft-knee log compression.
// ----------------------------------------------------------------------------
package pmlc_pkg;

   localparam int SAMPLE_FIELDS = 8;   // sample ports on the request side
   localparam int SAMPLE_W      = 16;
   localparam int CNT_W         = 4;   // channel_count register width
   localparam logic [CNT_W-1:0] CH_COUNT_RESET = CNT_W'(2);

   // full scale for positive and negative sums
   localparam int FS_POS = 32767;
   localparam int FS_NEG = 32768;

   // curve-region span t = 10m - 6FS stays below 14FS < 2^19
   localparam int T_W     = 19;
   localparam int FRAC_W  = 16;        // interpolation fraction
   localparam int ENTRY_W = 16;        // Q1.15 curve entries, max 1.0
   localparam int F_W     = ENTRY_W + 1;

   // divisors 14*FS and their truncated reciprocals
   localparam longint unsigned K_POS = 64'd14 * FS_POS;
   localparam longint unsigned K_NEG = 64'd14 * FS_NEG;
   localparam int RECIP1_SH = 32;
   localparam int RECIP2_SH = 36;
   localparam longint unsigned RECIP1_POS = (64'd1 << RECIP1_SH) / K_POS;
   localparam longint unsigned RECIP1_NEG = (64'd1 << RECIP1_SH) / K_NEG;
   localparam longint unsigned RECIP2_POS = (64'd1 << RECIP2_SH) / K_POS;
   localparam longint unsigned RECIP2_NEG = (64'd1 << RECIP2_SH) / K_NEG;
   localparam int R2_W = $clog2(RECIP2_POS + 64'd1);

   localparam longint unsigned ONE_Q28 = 64'd1 << 28;

   typedef enum logic [1:0] {
      MODE_PASS,   // below the knee, sum goes straight out
      MODE_CURVE,  // on the log curve
      MODE_FULL    // past the curve end, clamp to full scale
   } mode_type;

   // per-item side data that travels alongside the arithmetic
   typedef struct packed {
      logic                last;
      logic                neg;
      mode_type            mode;
      logic [SAMPLE_W-1:0] pass_val;
   } side_type;

   // log2 in Q28 by repeated squaring; used only to build the curve ROM
   function automatic longint unsigned log2_q28(input longint unsigned val);
      longint unsigned v;
      longint unsigned res;
      v   = val;
      res = 64'd0;
      for (int k = 0; k < 64; k++) begin
         if (v >= 2 * ONE_Q28) begin
            v   = v >> 1;
            res = res + ONE_Q28;
         end
      end
      for (int b = 27; b >= 0; b--) begin
         v = (v * v) >> 28;
         if (v >= 2 * ONE_Q28) begin
            v   = v >> 1;
            res = res | (64'd1 << b);
         end
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/pcm_mixer_log_compress.sv
// ----------------------------------------------------------------------------
// pcm_mixer_log_compress
// Sums up to eight PCM channels and applies a logarithmic soft-knee limiter.
// ----------------------------------------------------------------------------
// Usage: one request per clock. A request is taken on any edge with start
// high; busy is never raised and csr_ready is always high. Each result comes
// out on rsp_* with rsp_strobe high for one cycle, in request order; the
// receiver cannot stall and need not, as the pipeline never holds. The path
// holds eleven registers: input, adder chain, knee decision, the two
// reciprocal divisions by 14*FS (multiply, back-multiply, correct for each;
// the curve ROM read sits beside the second back-multiply), the
// interpolation multiply and the output register. channel_count may be
// written only while no request is in flight.
// ----------------------------------------------------------------------------
module pcm_mixer_log_compress #(
   parameter int CHANNELS          = 8,
   parameter int CURVE_TABLE_DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_0,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_1,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_2,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_3,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_4,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_5,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_6,
   input  logic signed [pmlc_pkg::SAMPLE_W-1:0]  req_sample_7,
   input  logic                                  req_last_in,
   // result channel
   output logic                                  rsp_strobe,
   output logic signed [pmlc_pkg::SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic                                  rsp_last_out,
   // channel_count register
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [pmlc_pkg::CNT_W-1:0]     csr_wdata
);
   import pmlc_pkg::*;

   // ---- derived sizes ----
   localparam int LANES   = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;
   localparam int SUM_W   = SAMPLE_W + $clog2(LANES);
   localparam int TEN_W   = SUM_W + 4;
   localparam int DEP_W   = $clog2(CURVE_TABLE_DEPTH + 1);
   localparam int ADDR_W  = DEP_W;
   localparam int STAGES  = 10;             // stage 0 input .. stage 9 interpolation
   localparam int SIDE_N  = STAGES - 2;     // side data from knee stage onwards
   localparam int LATENCY = STAGES + 1;

   // first division folds the table depth into the reciprocal
   localparam longint unsigned C1_POS = CURVE_TABLE_DEPTH * RECIP1_POS;
   localparam longint unsigned C1_NEG = CURVE_TABLE_DEPTH * RECIP1_NEG;
   localparam int C1_W = $clog2(C1_POS + 64'd1);
   localparam int P1_W = T_W + C1_W;
   localparam int X1_W = T_W + DEP_W;
   localparam int P2_W = T_W + R2_W;
   localparam int X2_W = T_W + FRAC_W;

   localparam logic [C1_W-1:0]  C1_POS_C  = C1_W'(C1_POS);
   localparam logic [C1_W-1:0]  C1_NEG_C  = C1_W'(C1_NEG);
   localparam logic [R2_W-1:0]  R2_POS_C  = R2_W'(RECIP2_POS);
   localparam logic [R2_W-1:0]  R2_NEG_C  = R2_W'(RECIP2_NEG);
   localparam logic [DEP_W-1:0] DEPTH_C   = DEP_W'(CURVE_TABLE_DEPTH);
   localparam logic [TEN_W-1:0] SIX_FS_P  = TEN_W'(6 * FS_POS);
   localparam logic [TEN_W-1:0] SIX_FS_N  = TEN_W'(6 * FS_NEG);
   localparam logic [SUM_W-1:0] TWO_FS_P  = SUM_W'(2 * FS_POS);
   localparam logic [SUM_W-1:0] TWO_FS_N  = SUM_W'(2 * FS_NEG);
   localparam logic [F_W-1:0]   FS_P_C    = F_W'(FS_POS);
   localparam logic [F_W-1:0]   FS_N_C    = F_W'(FS_NEG);
   localparam logic [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'(FS_POS);
   localparam logic [SAMPLE_W-1:0] OUT_MIN = SAMPLE_W'(FS_NEG);

   function automatic logic [T_W-1:0] div_of(input logic neg);
      return neg ? T_W'(K_NEG) : T_W'(K_POS);
   endfunction

   // ---- curve ROM, built at elaboration ----
   localparam longint unsigned U_END =
      ONE_Q28 + (64'(CURVE_TABLE_DEPTH) * ONE_Q28 * 64'd748) / (64'd100 * CURVE_TABLE_DEPTH);
   localparam longint unsigned L_END = log2_q28(U_END);
   localparam longint unsigned L_DEN = 64'd10 * L_END;

   logic [ENTRY_W-1:0] curve_rom [CURVE_TABLE_DEPTH+1];

   for (genvar g = 0; g <= CURVE_TABLE_DEPTH; g++) begin : g_curve
      localparam longint unsigned UI =
         ONE_Q28 + (64'(g) * ONE_Q28 * 64'd748) / (64'd100 * CURVE_TABLE_DEPTH);
      localparam longint unsigned LI    = log2_q28(UI);
      localparam longint unsigned NUM   = 64'd32768 * (64'd6 * L_END + 64'd4 * LI);
      localparam longint unsigned ENTRY = (NUM + L_DEN / 2) / L_DEN;
      assign curve_rom[g] = ENTRY_W'(ENTRY);
   end

   // ---- config register ----
   logic [CNT_W-1:0] channel_count_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CH_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         channel_count_ff <= csr_wdata;
      end
   end

   // ---- valid line ----
   logic               req_take;
   logic [STAGES-1:0]  vld_ff;
   logic               rsp_strobe_ff;

   assign req_take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= {vld_ff[STAGES-2:0], req_take};
         rsp_strobe_ff <= vld_ff[STAGES-1];
      end
   end

   // ---- stage 0: input register, inactive channels zeroed ----
   logic signed [SAMPLE_W-1:0] req_samples [SAMPLE_FIELDS];
   logic signed [SAMPLE_W-1:0] lane_ff     [LANES];
   logic                       in_last_ff;

   assign req_samples[0] = req_sample_0;
   assign req_samples[1] = req_sample_1;
   assign req_samples[2] = req_sample_2;
   assign req_samples[3] = req_sample_3;
   assign req_samples[4] = req_sample_4;
   assign req_samples[5] = req_sample_5;
   assign req_samples[6] = req_sample_6;
   assign req_samples[7] = req_sample_7;

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < LANES; i++) begin
            lane_ff[i] <= (CNT_W'(i) < channel_count_ff) ? req_samples[i] : '0;
         end
         in_last_ff <= req_last_in;
      end
   end

   // ---- stage 1: channel sum ----
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    a_last_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + SUM_W'(lane_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      a_last_ff <= in_last_ff;
   end

   // ---- stage 2: knee decision, curve offset t = 10m - 6FS ----
   logic              neg_in;
   logic [SUM_W-1:0]  mag_in;
   logic [TEN_W-1:0]  tenm_in;
   logic [TEN_W-1:0]  six_fs;
   logic [SUM_W-1:0]  two_fs;
   mode_type          mode_in;
   logic [T_W-1:0]    t_in;
   logic [T_W-1:0]    t_ff;
   side_type          side_ff [SIDE_N];

   always_comb begin
      neg_in  = sum_ff[SUM_W-1];
      mag_in  = neg_in ? unsigned'(-sum_ff) : unsigned'(sum_ff);
      tenm_in = {4'b0, mag_in} * TEN_W'(10);
      six_fs  = neg_in ? SIX_FS_N : SIX_FS_P;
      two_fs  = neg_in ? TWO_FS_N : TWO_FS_P;
      if (tenm_in > six_fs) begin
         mode_in = (mag_in >= two_fs) ? MODE_FULL : MODE_CURVE;
      end else begin
         mode_in = MODE_PASS;
      end
      // outside the curve t is parked at zero so the divider sees a sane value
      t_in = (mode_in == MODE_CURVE) ? T_W'(tenm_in - six_fs) : '0;
   end

   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      side_ff[0] <= '{last: a_last_ff, neg: neg_in, mode: mode_in,
                      pass_val: SAMPLE_W'(sum_ff)};
      for (int s = 1; s < SIDE_N; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   // ---- stage 3: idx estimate = t*D*R1 >> 32, may be one low ----
   logic [C1_W-1:0]   c1_sel;
   logic [P1_W-1:0]   prod1;
   logic [ADDR_W-1:0] q0_ff;
   logic [T_W-1:0]    t_c_ff;

   assign c1_sel = side_ff[0].neg ? C1_NEG_C : C1_POS_C;
   assign prod1  = {{C1_W{1'b0}}, t_ff} * {{T_W{1'b0}}, c1_sel};

   always_ff @(posedge clock) begin
      q0_ff  <= ADDR_W'(prod1 >> RECIP1_SH);
      t_c_ff <= t_ff;
   end

   // ---- stage 4: remainder t*D - q0*K ----
   logic [T_W-1:0]    k_d;
   logic [X1_W-1:0]   x1;
   logic [X1_W-1:0]   qk1;
   logic [T_W:0]      rem_in;
   logic [T_W:0]      rem_ff;
   logic [ADDR_W-1:0] q1_ff;

   assign k_d    = div_of(side_ff[1].neg);
   assign x1     = {{DEP_W{1'b0}}, t_c_ff} * {{T_W{1'b0}}, DEPTH_C};
   assign qk1    = {{T_W{1'b0}}, q0_ff} * {{ADDR_W{1'b0}}, k_d};
   assign rem_in = (T_W+1)'(x1 - qk1);

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q1_ff  <= q0_ff;
   end

   // ---- stage 5: single correction step gives idx and remainder ----
   logic [T_W-1:0]    k_e;
   logic [ADDR_W-1:0] qhi_in;
   logic [T_W-1:0]    r_in;
   logic [ADDR_W-1:0] qhi_e_ff;
   logic [T_W-1:0]    r_e_ff;

   always_comb begin
      k_e = div_of(side_ff[2].neg);
      if (rem_ff >= {1'b0, k_e}) begin
         qhi_in = q1_ff + ADDR_W'(1);
         r_in   = T_W'(rem_ff - {1'b0, k_e});
      end else begin
         qhi_in = q1_ff;
         r_in   = T_W'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      qhi_e_ff <= qhi_in;
      r_e_ff   <= r_in;
   end

   // ---- stage 6: frac estimate = r*2^16 / K via reciprocal ----
   logic [R2_W-1:0]   r2_sel;
   logic [P2_W-1:0]   prod2;
   logic [FRAC_W-1:0] q2_f_ff;
   logic [ADDR_W-1:0] qhi_f_ff;
   logic [T_W-1:0]    r_f_ff;

   assign r2_sel = side_ff[3].neg ? R2_NEG_C : R2_POS_C;
   assign prod2  = {{R2_W{1'b0}}, r_e_ff} * {{T_W{1'b0}}, r2_sel};

   always_ff @(posedge clock) begin
      q2_f_ff  <= FRAC_W'(prod2 >> (RECIP2_SH - FRAC_W));
      qhi_f_ff <= qhi_e_ff;
      r_f_ff   <= r_e_ff;
   end

   // ---- stage 7: frac remainder, curve ROM read ----
   logic [T_W-1:0]     k_g;
   logic [X2_W-1:0]    x2;
   logic [X2_W-1:0]    qk2;
   logic [ADDR_W-1:0]  qhi_next;
   logic [T_W:0]       rem2_ff;
   logic [FRAC_W-1:0]  q2_g_ff;
   logic [ENTRY_W-1:0] e0_g_ff;
   logic [ENTRY_W-1:0] e1_g_ff;

   assign k_g      = div_of(side_ff[4].neg);
   assign x2       = {r_f_ff, {FRAC_W{1'b0}}};
   assign qk2      = {{T_W{1'b0}}, q2_f_ff} * {{FRAC_W{1'b0}}, k_g};
   assign qhi_next = qhi_f_ff + ADDR_W'(1);

   always_ff @(posedge clock) begin
      rem2_ff <= (T_W+1)'(x2 - qk2);
      q2_g_ff <= q2_f_ff;
      e0_g_ff <= curve_rom[qhi_f_ff];
      e1_g_ff <= curve_rom[qhi_next];
   end

   // ---- stage 8: frac correction ----
   logic [T_W-1:0]     k_h;
   logic [FRAC_W-1:0]  frac_h_ff;
   logic [ENTRY_W-1:0] e0_h_ff;
   logic [ENTRY_W-1:0] e1_h_ff;

   assign k_h = div_of(side_ff[5].neg);

   always_ff @(posedge clock) begin
      frac_h_ff <= q2_g_ff + FRAC_W'(rem2_ff >= {1'b0, k_h});
      e0_h_ff   <= e0_g_ff;
      e1_h_ff   <= e1_g_ff;
   end

   // ---- stage 9: linear interpolation ----
   logic [ENTRY_W-1:0]        e_diff;
   logic [ENTRY_W+FRAC_W-1:0] prod3;
   logic [F_W-1:0]            f_ff;

   assign e_diff = e1_h_ff - e0_h_ff;   // curve is monotonic rising
   assign prod3  = {{FRAC_W{1'b0}}, e_diff} * {{ENTRY_W{1'b0}}, frac_h_ff};

   always_ff @(posedge clock) begin
      f_ff <= {1'b0, e0_h_ff} + {1'b0, prod3[ENTRY_W+FRAC_W-1:FRAC_W]};
   end

   // ---- output: scale to full scale, sign, clamp ----
   // f*FS with FS = 2^15 - 1 or 2^15 needs only a shift and a subtract.
   localparam int WIDE_W = F_W + 15;

   side_type             side_o;
   logic [WIDE_W-1:0]    wide;
   logic [F_W-1:0]       mag_c;
   logic [F_W-1:0]       fs_sel;
   logic [F_W-1:0]       mag_cap;
   logic [SAMPLE_W-1:0]  curve_val;
   logic [SAMPLE_W-1:0]  rsp_sample_in;
   logic [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                 rsp_last_ff;

   always_comb begin
      side_o    = side_ff[SIDE_N-1];
      wide      = {f_ff, 15'b0} - (side_o.neg ? '0 : {15'b0, f_ff}) + WIDE_W'(16384);
      mag_c     = F_W'(wide >> 15);
      fs_sel    = side_o.neg ? FS_N_C : FS_P_C;
      mag_cap   = (mag_c > fs_sel) ? fs_sel : mag_c;
      curve_val = side_o.neg ? SAMPLE_W'(-mag_cap) : SAMPLE_W'(mag_cap);
      unique case (side_o.mode)
         MODE_PASS:  rsp_sample_in = side_o.pass_val;
         MODE_CURVE: rsp_sample_in = curve_val;
         MODE_FULL:  rsp_sample_in = side_o.neg ? OUT_MIN : OUT_MAX;
         default:    rsp_sample_in = side_o.pass_val;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= side_o.last;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_mixed_sample = signed'(rsp_sample_ff);
   assign rsp_last_out     = rsp_last_ff;

   // ---- assertions ----
   // every strobe traces back to a request a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without matching request");

   // reciprocal estimate of idx is never more than one low
   a_idx_est: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (rem_ff < {k_e, 1'b0}))
      else $error("idx estimate off by more than one");

   // corrected idx stays inside the table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (qhi_e_ff < DEPTH_C))
      else $error("curve index beyond table");

   // reciprocal estimate of frac is never more than one low
   a_frac_est: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] |-> (rem2_ff < {div_of(side_ff[5].neg), 1'b0}))
      else $error("frac estimate off by more than one");

endmodule

FILE: sim/tb_pcm_mixer_log_compress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_mixer_log_compress
// Self-checking bench for the eight-channel PCM mixer with soft-knee log
// compression. Requests are queued by a stimulus process and driven through
// the start/busy handshake. A behavioural model is fed each accepted request
// and predicts the mixed sample and last flag. A monitor compares every rsp_
// strobe against the oldest prediction. Runs through several channel_count
// settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_pcm_mixer_log_compress;
   import pmlc_pkg::*;

   localparam int CHANNELS          = 8;
   localparam int CURVE_TABLE_DEPTH = 256;
   localparam int CLK_HALF          = 10;
   localparam int RESET_CYCLES      = 8;
   localparam int DRAIN_CYCLES      = 16;    // pipeline is 11 deep, plus slack
   localparam int QUIET_LIMIT       = 5000;  // cycles with no handshake at all
   localparam int RANDOM_PER_PHASE  = 155;
   localparam int NUM_PHASES        = 12;

   // one request: eight channel samples plus the end-of-block flag
   typedef struct packed {
      logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] smp;
      logic                                   last;
   } mix_frame_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mixed;
      logic                last;
   } mix_result_type;

   // how the random samples of one request are drawn
   typedef enum int {
      MIX_ANY,        // fully random bits
      MIX_LOUD_POS,   // all loud and positive, mostly drives the sum past the knee
      MIX_LOUD_NEG,   // same on the negative side
      MIX_EDGES       // full-scale, zero and near-zero values
   } mix_shape_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [SAMPLE_W-1:0] req_sample_0 = '0;
   logic [SAMPLE_W-1:0] req_sample_1 = '0;
   logic [SAMPLE_W-1:0] req_sample_2 = '0;
   logic [SAMPLE_W-1:0] req_sample_3 = '0;
   logic [SAMPLE_W-1:0] req_sample_4 = '0;
   logic [SAMPLE_W-1:0] req_sample_5 = '0;
   logic [SAMPLE_W-1:0] req_sample_6 = '0;
   logic [SAMPLE_W-1:0] req_sample_7 = '0;
   logic                req_last_in  = 1'b0;
   logic                rsp_strobe;
   logic [SAMPLE_W-1:0] rsp_mixed_sample;
   logic                rsp_last_out;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_wdata = '0;

   // bench-side copy of the channel_count register
   logic [CNT_W-1:0]    mix_count = CH_COUNT_RESET;

   // Q1.15 knee curve, rebuilt here from its definition
   longint unsigned     knee_curve [0:CURVE_TABLE_DEPTH];

   mix_frame_type       frame_q [$];          // requests waiting to be driven
   mix_result_type      expected_mix_q [$];   // predictions awaiting a strobe
   mix_frame_type       held_frame;           // request currently on req_*
   int                  idle_pct = 0;
   int                  mismatches = 0;
   int                  quiet_cycles = 0;

   int unsigned phase_counts [NUM_PHASES] = '{2, 1, 8, 15, 0, 3, 5, 8, 4, 6, 7, 2};

   pcm_mixer_log_compress #(
      .CHANNELS          (CHANNELS),
      .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_0     (req_sample_0),
      .req_sample_1     (req_sample_1),
      .req_sample_2     (req_sample_2),
      .req_sample_3     (req_sample_3),
      .req_sample_4     (req_sample_4),
      .req_sample_5     (req_sample_5),
      .req_sample_6     (req_sample_6),
      .req_sample_7     (req_sample_7),
      .req_last_in      (req_last_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_last_out     (rsp_last_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Knee curve construction
   // ------------------------------------------------------------------------

   // log2 in Q28 by repeated squaring: integer part from normalising into
   // [1,2), then one fraction bit per squaring step
   function automatic longint unsigned curve_log2(input longint unsigned val);
      longint unsigned v;
      longint unsigned acc;
      v   = val;
      acc = 64'd0;
      while (v >= (64'd2 << 28)) begin
         v   = v >> 1;
         acc = acc + (64'd1 << 28);
      end
      for (int b = 27; b >= 0; b--) begin
         v = (v * v) >> 28;
         if (v >= (64'd2 << 28)) begin
            v   = v >> 1;
            acc = acc | (64'd1 << b);
         end
      end
      return acc;
   endfunction

   // 1 + 7.48*i/D in Q4.28
   function automatic longint unsigned knee_point(input longint unsigned i);
      return (64'd1 << 28) + (i * (64'd1 << 28) * 64'd748) / (64'd100 * CURVE_TABLE_DEPTH);
   endfunction

   function automatic void build_knee_curve();
      longint unsigned l_end;
      longint unsigned li;
      longint unsigned num;
      longint unsigned den;
      l_end = curve_log2(knee_point(CURVE_TABLE_DEPTH));
      den   = 64'd10 * l_end;
      for (int i = 0; i <= CURVE_TABLE_DEPTH; i++) begin
         li  = curve_log2(knee_point(i));
         num = 64'd32768 * (64'd6 * l_end + 64'd4 * li);
         knee_curve[i] = (num + den / 2) / den;   // round half up
      end
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // magnitude above the knee -> compressed magnitude, FS = full scale of
   // the sign in question (32767 positive, 32768 negative)
   function automatic int knee_squash(input int unsigned m, input int unsigned fs);
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned f;
      longint unsigned mag;
      pos  = (((64'(m) * 64'd10 - 64'(fs) * 64'd6) * CURVE_TABLE_DEPTH) << 16)
             / (64'(fs) * 64'd14);
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      // x >= 2: past the end of the curve, clamp to full scale
      if (idx >= CURVE_TABLE_DEPTH)
         return int'(fs);
      f   = knee_curve[idx] + (((knee_curve[idx + 1] - knee_curve[idx]) * frac) >> 16);
      mag = (f * fs + 64'd16384) >> 15;
      if (mag > fs)
         mag = fs;
      return int'(mag);
   endfunction

   function automatic mix_result_type mix_and_compress(input mix_frame_type fr,
                                                       input logic [CNT_W-1:0] cnt);
      mix_result_type r;
      int             n;
      int             sum;
      int             res;
      // counts above the channel limit saturate; zero gives a silent sum
      n = cnt;
      if (n > CHANNELS)
         n = CHANNELS;
      if (n > SAMPLE_FIELDS)
         n = SAMPLE_FIELDS;
      sum = 0;
      for (int i = 0; i < n; i++)
         sum += $signed(fr.smp[i]);
      if (sum > 0 && 10 * sum > 6 * FS_POS)
         res = knee_squash(sum, FS_POS);
      else if (sum < 0 && 10 * sum < -6 * FS_NEG)
         res = -knee_squash(-sum, FS_NEG);
      else
         res = sum;
      r.mixed = res[SAMPLE_W-1:0];
      r.last  = fr.last;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [SAMPLE_W-1:0] draw_sample(input mix_shape_type shape);
      case (shape)
         MIX_ANY:      return SAMPLE_W'($urandom);
         MIX_LOUD_POS: return SAMPLE_W'($urandom_range(8192, 32767));
         MIX_LOUD_NEG: return SAMPLE_W'(-int'($urandom_range(8192, 32768)));
         default: begin
            case ($urandom_range(0, 3))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               2:       return 16'h0000;
               default: return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
            endcase
         end
      endcase
   endfunction

   // channels 0 and 1 set, the rest random (ignored at a count of two)
   task automatic push_pair(input int a, input int b, input bit fin);
      mix_frame_type fr;
      for (int i = 2; i < SAMPLE_FIELDS; i++)
         fr.smp[i] = SAMPLE_W'($urandom);
      fr.smp[0] = SAMPLE_W'(a);
      fr.smp[1] = SAMPLE_W'(b);
      fr.last   = fin;
      frame_q.push_back(fr);
   endtask

   task automatic push_all(input int v);
      mix_frame_type fr;
      for (int i = 0; i < SAMPLE_FIELDS; i++)
         fr.smp[i] = SAMPLE_W'(v);
      fr.last = 1'b0;
      frame_q.push_back(fr);
   endtask

   task automatic push_random();
      mix_frame_type fr;
      mix_shape_type shape;
      shape = mix_shape_type'($urandom_range(0, 3));
      for (int i = 0; i < SAMPLE_FIELDS; i++)
         fr.smp[i] = draw_sample(shape);
      fr.last = ($urandom_range(0, 15) == 0);
      frame_q.push_back(fr);
   endtask

   // register writes go in only with nothing in flight
   task automatic write_channel_count(input logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      mix_count = v;
      csr_valid <= 1'b0;
   endtask

   // checked on the falling edge so that every update of the rising edge
   // has settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (frame_q.size() != 0 || start || expected_mix_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: a request is taken on an edge with start high and busy
   // low. The prediction is made at that edge, using the register value in
   // force. A new request is offered only once the held one has gone.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_mix_q.push_back(mix_and_compress(held_frame, mix_count));
         if (!start || !busy) begin
            if (frame_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               held_frame = frame_q.pop_front();
               start        <= 1'b1;
               req_sample_0 <= held_frame.smp[0];
               req_sample_1 <= held_frame.smp[1];
               req_sample_2 <= held_frame.smp[2];
               req_sample_3 <= held_frame.smp[3];
               req_sample_4 <= held_frame.smp[4];
               req_sample_5 <= held_frame.smp[5];
               req_sample_6 <= held_frame.smp[6];
               req_sample_7 <= held_frame.smp[7];
               req_last_in  <= held_frame.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: every strobe must match the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      mix_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_mix_q.size() == 0) begin
            $display("%0t unexpected result: mixed_sample %0d last_out %0b",
                     $time, $signed(rsp_mixed_sample), rsp_last_out);
            mismatches++;
         end else begin
            want = expected_mix_q.pop_front();
            if (rsp_mixed_sample !== want.mixed) begin
               $display("%0t mixed_sample expected %0d got %0d", $time,
                        $signed(want.mixed), $signed(rsp_mixed_sample));
               mismatches++;
            end
            if (rsp_last_out !== want.last) begin
               $display("%0t last_out expected %0b got %0b", $time,
                        want.last, rsp_last_out);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: gives up after a long stretch with no handshake of any kind
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
         $display("[pcm_mixer_log_compress] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Phases: each sets the sender idle rate and, after the first, channel_count,
   // then queues its requests and waits for every result before the next register write.
   // ------------------------------------------------------------------------
   initial begin
      build_knee_curve();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         // first phase runs on the reset value of the register
         if (p != 0)
            write_channel_count(CNT_W'(phase_counts[p]));
         case (p % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 88;
            default: idle_pct = 14;
         endcase

         if (p == 0) begin
            // two channels: knee edges on both signs, x = 1 and x = 2
            push_pair(32767, 32767, 1'b0);     // exactly 2*FS, clamps
            push_pair(-32768, -32768, 1'b0);   // exactly -2*FS, clamps
            push_pair(32767, 32766, 1'b0);     // last interval of the curve
            push_pair(-32768, -32767, 1'b0);
            push_pair(19660, 0, 1'b0);         // highest positive pass-through
            push_pair(19661, 0, 1'b0);         // first positive on the curve
            push_pair(-19660, 0, 1'b0);        // lowest negative pass-through
            push_pair(-19661, 0, 1'b0);        // first negative on the curve
            push_pair(32767, 0, 1'b0);
            push_pair(-32768, 0, 1'b0);
            push_pair(25000, 0, 1'b0);
            push_pair(-30000, 0, 1'b0);
            push_pair(32767, -32768, 1'b0);
            push_pair(-1, 1, 1'b0);
            push_pair(0, 0, 1'b1);
         end else if (phase_counts[p] == 8 || phase_counts[p] == 15 ||
                      phase_counts[p] == 0) begin
            // full-scale on every channel: deep clamp, saturated count, or
            // silence when no channel is summed
            push_all(32767);
            push_all(-32768);
         end

         repeat (RANDOM_PER_PHASE) push_random();
         wait_drained();
      end

      if (mismatches == 0)
         $display("[pcm_mixer_log_compress] OK");
      else
         $display("[pcm_mixer_log_compress] ERROR");
      $finish;
   end

endmodule
